FILE: design/assert_macros.svh
// Assertion helpers used by the deframer design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: design/ffd_pkg.sv
`timescale 1ns / 1ps
package ffd_pkg;
   localparam int FRAME_BYTES = 26;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int NUM_WORDS   = 11;

   localparam logic [7:0] SYNC_LOW  = 8'hCD;
   localparam logic [7:0] SYNC_HIGH = 8'hAB;

   localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_XLAST = POS_W'(FRAME_BYTES - 2);

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef logic [15:0] word_type;
endpackage

FILE: design/feedback_frame_deframer.sv
`timescale 1ns / 1ps
// Serial feedback frame deframer.
// The req channel carries one received byte per word, in arrival order. The block
// hunts for the little-endian start word 0xABCD, collects the rest of the frame and
// checks the trailing word against the XOR of all earlier even-offset words.
// Each completed frame gives one word on the rsp channel: a status bit (0 ok,
// 1 checksum error with all fields forced to zero) and eleven 16-bit fields.
// Throughput: one byte per cycle while req_stall is low. Each byte is handled by one pass of
// logic between the frame state registers and the result register.
// Latency: the result is valid in the cycle after the last frame byte is accepted.
// The result register lets a new byte be accepted in the same cycle the previous
// result is taken. req_stall is raised only while a result is held and the
// receiver stalls it; the held result then does not change.
// Reset clears the position (back to hunting), the checksum and the result valid.
`include "assert_macros.svh"

module feedback_frame_deframer import ffd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_frame_status,
   output logic signed [15:0] rsp_command_one,
   output logic signed [15:0] rsp_command_two,
   output logic signed [15:0] rsp_right_speed,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_count,
   output logic signed [15:0] rsp_left_count,
   output logic signed [15:0] rsp_battery_centivolts,
   output logic signed [15:0] rsp_board_decidegrees,
   output logic        [15:0] rsp_led_word,
   output logic        [15:0] rsp_driver_mode,
   output logic        [15:0] rsp_ack_word
);

   logic [POS_W-1:0] pos_ff, pos_in;
   word_type         xor_ff, xor_in;
   logic [7:0]       pending_ff, pending_in;
   logic [7:0]       bytes_ff [FRAME_BYTES];
   logic             rsp_valid_ff, rsp_valid_in;
   logic             status_ff;
   word_type         word_ff [NUM_WORDS];

   logic     accept;
   logic     store_en;
   logic     frame_done;
   logic     frame_ok;
   word_type trailer;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // The last byte is still on the input when the frame completes.
   assign trailer  = {req_rx_byte, bytes_ff[POS_XLAST]};
   assign frame_ok = (trailer == xor_ff);

   always_comb begin
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      pending_in = pending_ff;
      store_en   = 1'b0;
      frame_done = 1'b0;
      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_rx_byte == SYNC_LOW) begin
               pos_in     = POS_SYNC;
               xor_in     = '0;
               pending_in = req_rx_byte;
            end
         end else if (pos_ff == POS_SYNC && req_rx_byte != SYNC_HIGH) begin
            if (req_rx_byte == SYNC_LOW) begin
               pos_in     = POS_SYNC;
               xor_in     = '0;
               pending_in = req_rx_byte;
            end else begin
               pos_in = POS_HUNT;
            end
         end else begin
            store_en = 1'b1;
            if (!pos_ff[0]) begin
               pending_in = req_rx_byte;
            end else if (pos_ff < POS_LAST) begin
               xor_in = xor_ff ^ {req_rx_byte, pending_ff};
            end
            if (pos_ff == POS_LAST) begin
               frame_done = 1'b1;
               pos_in     = POS_HUNT;
               xor_in     = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (frame_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_HUNT;
         xor_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pending_ff <= pending_in;
      if (store_en) begin
         bytes_ff[pos_ff] <= req_rx_byte;
      end
      if (frame_done) begin
         status_ff <= frame_ok ? STATUS_OK : STATUS_BAD;
         for (int k = 0; k < NUM_WORDS; k++) begin
            word_ff[k] <= frame_ok ? {bytes_ff[2*k+3], bytes_ff[2*k+2]} : '0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_frame_status       = status_ff;
   assign rsp_command_one        = word_ff[0];
   assign rsp_command_two        = word_ff[1];
   assign rsp_right_speed        = word_ff[2];
   assign rsp_left_speed         = word_ff[3];
   assign rsp_right_count        = word_ff[4];
   assign rsp_left_count         = word_ff[5];
   assign rsp_battery_centivolts = word_ff[6];
   assign rsp_board_decidegrees  = word_ff[7];
   assign rsp_led_word           = word_ff[8];
   assign rsp_driver_mode        = word_ff[9];
   assign rsp_ack_word           = word_ff[10];

   `ASSERT_NEXT(a_done_gives_result, clock, reset, frame_done, rsp_valid_ff)
   `ASSERT_NEXT(a_done_rehunts, clock, reset, frame_done, pos_ff == POS_HUNT)
   `ASSERT_SAME(a_result_from_frame, clock, reset, $rose(rsp_valid_ff), $past(frame_done))
   `ASSERT_SAME(a_bad_fields_zero, clock, reset,
      rsp_valid_ff && status_ff == STATUS_BAD, word_ff[0] == '0 && word_ff[10] == '0)

endmodule
